// ===== rtl/core/unix_seconds_to_date_macros.svh =====
// Assertion macros for the timestamp-to-date core.
// Included by unix_seconds_to_date.sv; depends on nothing else.
`ifndef UNIX_SECONDS_TO_DATE_MACROS_SVH
`define UNIX_SECONDS_TO_DATE_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define USTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Check that cons holds in the cycle after ante.
`define USTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define USTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define USTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ustd_pkg.sv =====
// Constants and helpers for the timestamp-to-date core.
// No dependencies; imported by unix_seconds_to_date.
package ustd_pkg;

    localparam int unsigned SECS_W  = 32;
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned CYC_W   = 6;
    localparam int unsigned REM_W   = 11;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;

    // First second of 2100-01-01.
    localparam logic [SECS_W-1:0] LIMIT_SECS = 32'd4102444800;

    // secs / 86400 = (secs >> 7) / 675; reciprocal exact for 25-bit dividends.
    localparam int unsigned        Q_W         = 25;
    localparam int unsigned        RECIP675_SH = 35;
    localparam logic [25:0]        RECIP675    = 26'd50903317;
    // days / 1461, exact for 16-bit dividends.
    localparam int unsigned        RECIP1461_SH = 27;
    localparam logic [16:0]        RECIP1461    = 17'd91868;

    localparam logic [DAYS_W-1:0]  DAYS_1969    = 16'd365;
    localparam logic [REM_W-1:0]   DAYS_PER_CYC = 11'd1461;
    localparam logic [YEAR_W-1:0]  BASE_YEAR    = 12'd1969;

    typedef logic [DOY_W-1:0] doy_t;

    // Day of year on which month idx (0 = January) starts.
    function automatic doy_t month_start(input logic [MONTH_W-1:0] idx, input logic leap);
        doy_t base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && idx >= 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ===== rtl/core/unix_seconds_to_date.sv =====
// Unix timestamp to Gregorian date (1970..2099), fully pipelined.
// Throughput: one transaction per cycle; each stage holds only under output backpressure.
// Reset: aresetn (synchronous, active low) empties every stage; payload is not cleared.
// Stages: input reg, days (multiply by reciprocal of 675), four-year cycle (reciprocal
// of 1461), year and day-of-year, month lookup into the result register.
`include "unix_seconds_to_date_macros.svh"

module unix_seconds_to_date (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] unix_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] year, [15:12] month, [20:16] day_of_month, zero pad
    output logic [0:0]  m_tuser    // [0] out_of_range
);
    import ustd_pkg::*;

    // Stage valids and per-stage ready: a stage loads when empty or when it drains.
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_tvalid_reg;
    logic r1, r2, r3, r4, r_out;

    assign r_out    = !m_tvalid_reg || m_tready;
    assign r4       = !v4_reg || r_out;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign s_tready = r1;
    assign m_tvalid = m_tvalid_reg;

    // Stage 1: capture the timestamp.
    logic [SECS_W-1:0] secs_reg;

    // Stage 2: whole days counted from 1969-01-01.
    logic [Q_W-1:0]           q;
    logic [Q_W+26-1:0]        prod1;
    logic [DAYS_W-1:0]        days_next, days_reg;
    logic                     oor2_next, oor2_reg;

    assign q         = secs_reg[SECS_W-1:7];
    assign prod1     = {26'd0, q} * {{Q_W{1'b0}}, RECIP675};
    assign days_next = prod1[RECIP675_SH+DAYS_W-1:RECIP675_SH] + DAYS_1969;
    assign oor2_next = (secs_reg >= LIMIT_SECS);

    // Stage 3: number of whole four-year cycles.
    logic [DAYS_W+17-1:0] prod2;
    logic [CYC_W-1:0]     cyc_next, cyc_reg;
    logic [DAYS_W-1:0]    days3_reg;
    logic                 oor3_reg;

    assign prod2    = {17'd0, days_reg} * {{DAYS_W{1'b0}}, RECIP1461};
    assign cyc_next = prod2[RECIP1461_SH+CYC_W-1:RECIP1461_SH];

    // Stage 4: year within the cycle and day of year.
    logic [DAYS_W:0]     cyc_days;
    logic [DAYS_W:0]     rem_full;
    logic [REM_W-1:0]    rem;
    logic [1:0]          yy;
    logic [DOY_W-1:0]    doy_next, doy_reg;
    logic [YEAR_W-1:0]   year_next, year_reg;
    logic                leap_next, leap_reg;
    logic                oor4_reg;

    assign cyc_days = 17'(cyc_reg) * 17'(DAYS_PER_CYC);
    assign rem_full = {1'b0, days3_reg} - cyc_days;
    assign rem      = rem_full[REM_W-1:0];

    always_comb begin
        if (rem >= 11'd1095) begin
            yy       = 2'd3;
            doy_next = DOY_W'(rem - 11'd1095);
        end else if (rem >= 11'd730) begin
            yy       = 2'd2;
            doy_next = DOY_W'(rem - 11'd730);
        end else if (rem >= 11'd365) begin
            yy       = 2'd1;
            doy_next = DOY_W'(rem - 11'd365);
        end else begin
            yy       = 2'd0;
            doy_next = DOY_W'(rem);
        end
    end

    // Cycles start in 1969, so the last year of each cycle is the leap year.
    assign leap_next = (yy == 2'd3);
    assign year_next = BASE_YEAR + YEAR_W'({cyc_reg, 2'b00}) + YEAR_W'(yy);

    // Result stage: month by comparing day of year against month starts.
    logic [MONTH_W-1:0] mon_idx;
    logic [DOY_W-1:0]   day_off;
    logic [23:0]        m_tdata_next, m_tdata_reg;
    logic               m_tuser_next, m_tuser_reg;

    always_comb begin
        mon_idx = '0;
        for (int i = 1; i < 12; i++) begin
            if (doy_reg >= month_start(MONTH_W'(i), leap_reg)) begin
                mon_idx = MONTH_W'(i);
            end
        end
    end

    assign day_off = doy_reg - month_start(mon_idx, leap_reg);

    always_comb begin
        m_tuser_next = oor4_reg;
        if (oor4_reg) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = {3'b000,
                            DAY_W'(day_off + 9'd1),
                            mon_idx + 4'd1,
                            year_reg};
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // Valid chain: clear on reset, advance each stage when it may load.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= s_tvalid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
            if (r4) begin
                v4_reg <= v3_reg;
            end
            if (r_out) begin
                m_tvalid_reg <= v4_reg;
            end
        end
    end

    // Payload: hold while the stage is stalled.
    always_ff @(posedge aclk) begin
        if (r1) begin
            secs_reg <= s_tdata;
        end
        if (r2) begin
            days_reg <= days_next;
            oor2_reg <= oor2_next;
        end
        if (r3) begin
            cyc_reg   <= cyc_next;
            days3_reg <= days_reg;
            oor3_reg  <= oor2_reg;
        end
        if (r4) begin
            year_reg <= year_next;
            doy_reg  <= doy_next;
            leap_reg <= leap_next;
            oor4_reg <= oor3_reg;
        end
        if (r_out) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // An out-of-range result carries an all-zero date.
    `USTD_ASSERT_IMP(a_oor_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 24'd0)
    // An in-range result has a month of 1..12 and a nonzero day.
    `USTD_ASSERT_IMP(a_date_legal, aclk, aresetn, m_tvalid && !m_tuser[0], (m_tdata[15:12] != 4'd0) && (m_tdata[15:12] <= 4'd12) && (m_tdata[20:16] != 5'd0))
    // An accepted transaction always lands in the first stage.
    `USTD_ASSERT_NXT(a_accept_loads, aclk, aresetn, s_tvalid && s_tready, v1_reg)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for unix_seconds_to_date: stream timestamps in, dates out.
// Needs only the RTL (unix_seconds_to_date, the ustd_pkg it imports and its macro header).
// Expected dates come from a table of known values or from an in-bench date calculator.
`timescale 1ns / 100ps

module tb_top;

    // First second of 2100-01-01; everything at or past it is out of range.
    localparam logic [31:0] END_OF_2099 = 32'd4102444800;
    // Whole days from 1970-01-01 to 2100-01-01 (130 years, 32 of them leap).
    localparam int unsigned DAYS_IN_SPAN = 47482;
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned DAYS_PER_QUAD = 1461;
    localparam int unsigned NUM_RANDOM = 900;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        oor;
    } date_t;

    typedef struct {
        logic [31:0] secs;
        logic        typed;   // 1: use the date given in the row, 0: compute it
        date_t       want;
    } stamp_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;    // [31:0] unix_seconds
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [11:0] year, [15:12] month, [20:16] day_of_month
    logic [0:0]  m_tuser;            // [0] out_of_range

    date_t      date_q[$];          // dates still owed by the block, oldest first
    stamp_row_t stamp_table[$];
    int         idle_pct = 11;      // chance per cycle that either side idles
    int         err_count = 0;

    unix_seconds_to_date dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Calendar date of a timestamp. Count days from 1969-01-01 so each
    // four-year block ends on its leap year, then peel off years and months.
    function automatic date_t calc_date(input logic [31:0] secs);
        int unsigned days, quad, rem, yy, doy, m, len, yr;
        date_t r;
        r = '0;
        if (secs >= END_OF_2099) begin
            r.oor = 1'b1;
            return r;
        end
        days = secs / SECS_PER_DAY + 365;
        quad = days / DAYS_PER_QUAD;
        rem  = days % DAYS_PER_QUAD;
        yy   = rem / 365;
        // The last day of a leap year would otherwise roll into a fifth year.
        if (yy > 3) begin
            yy = 3;
        end
        yr  = 1969 + 4 * quad + yy;
        doy = rem - 365 * yy;
        for (m = 0; m < 11; m++) begin
            case (m)
                1:          len = (yr % 4 == 0) ? 29 : 28;
                3, 5, 8, 10: len = 30;
                default:    len = 31;
            endcase
            if (doy < len) begin
                break;
            end
            doy -= len;
        end
        r.year  = yr[11:0];
        r.month = 4'(m + 1);
        r.day   = 5'(doy + 1);
        return r;
    endfunction

    task automatic add_row(input logic [31:0] secs, input logic typed,
                           input int y, input int mo, input int d, input logic oor);
        stamp_row_t row;
        row.secs       = secs;
        row.typed      = typed;
        row.want.year  = 12'(y);
        row.want.month = 4'(mo);
        row.want.day   = 5'(d);
        row.want.oor   = oor;
        stamp_table.push_back(row);
    endtask

    task automatic report(input string what, input date_t got, input date_t exp);
        err_count++;
        $display("MISMATCH %s: got %0d-%0d-%0d oor=%0b, expected %0d-%0d-%0d oor=%0b",
                 what, got.year, got.month, got.day, got.oor,
                 exp.year, exp.month, exp.day, exp.oor);
    endtask

    // Present one timestamp, hold it until the transaction completes, then
    // log the date it must produce. Idle cycles go in front at random.
    task automatic send_stamp(input logic [31:0] secs, input logic typed, input date_t want);
        date_t exp;
        exp = typed ? want : calc_date(secs);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        do @(posedge aclk); while (!s_tready);
        date_q.push_back(exp);
    endtask

    // Random timestamp. Most land on a random day inside 1970..2099 with a
    // random time of day; some crowd the 2100 boundary; the rest use all 32 bits.
    function automatic logic [31:0] pick_stamp();
        logic [31:0] secs;
        case ($urandom_range(0, 9))
            7: secs = END_OF_2099 - 32'd50000 + 32'($urandom_range(0, 100000));
            8, 9: secs = $urandom;
            default: begin
                secs = 32'($urandom_range(0, DAYS_IN_SPAN - 1)) * 32'(SECS_PER_DAY)
                     + 32'($urandom_range(0, SECS_PER_DAY - 1));
            end
        endcase
        return secs;
    endfunction

    // Result side: stall at random and check every date transaction against
    // the oldest expectation.
    always @(posedge aclk) begin
        date_t got, exp;
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.year  = m_tdata[11:0];
            got.month = m_tdata[15:12];
            got.day   = m_tdata[20:16];
            got.oor   = m_tuser[0];
            if (date_q.size() == 0) begin
                report("unexpected result", got, got);
            end else begin
                exp = date_q.pop_front();
                if (got.year !== exp.year) report("year", got, exp);
                if (got.month !== exp.month) report("month", got, exp);
                if (got.day !== exp.day) report("day_of_month", got, exp);
                if (got.oor !== exp.oor) report("out_of_range", got, exp);
            end
        end
    end

    initial begin
        date_t none;
        none = '0;

        // Directed rows: day and month rollovers, leap days, the signed
        // 32-bit rollover, and both sides of the end of 2099.
        add_row(32'd0,          1'b1, 1970, 1, 1, 1'b0);
        add_row(32'd86399,      1'b1, 1970, 1, 1, 1'b0);
        add_row(32'd86400,      1'b1, 1970, 1, 2, 1'b0);
        add_row(32'd2678399,    1'b1, 1970, 1, 31, 1'b0);
        add_row(32'd2678400,    1'b1, 1970, 2, 1, 1'b0);
        add_row(32'd68169600,   1'b0, 0, 0, 0, 1'b0);   // 1972 leap day
        add_row(32'd68256000,   1'b0, 0, 0, 0, 1'b0);   // day after it
        add_row(32'd94521600,   1'b0, 0, 0, 0, 1'b0);   // day before the last day of a leap year
        add_row(32'd94608000,   1'b0, 0, 0, 0, 1'b0);
        add_row(32'd946684799,  1'b1, 1999, 12, 31, 1'b0);
        add_row(32'd946684800,  1'b1, 2000, 1, 1, 1'b0);
        add_row(32'd951782400,  1'b0, 0, 0, 0, 1'b0);
        add_row(32'd951868800,  1'b0, 0, 0, 0, 1'b0);
        add_row(32'd2147483647, 1'b1, 2038, 1, 19, 1'b0);
        add_row(32'd2147483648, 1'b0, 0, 0, 0, 1'b0);
        add_row(32'h55555555,   1'b0, 0, 0, 0, 1'b0);
        add_row(32'hAAAAAAAA,   1'b0, 0, 0, 0, 1'b0);
        add_row(32'd4102444799, 1'b1, 2099, 12, 31, 1'b0);
        add_row(32'd4102444800, 1'b1, 0, 0, 0, 1'b1);
        add_row(32'd4102444801, 1'b1, 0, 0, 0, 1'b1);
        add_row(32'd4107542399, 1'b1, 0, 0, 0, 1'b1);
        add_row(32'hFFFFFFFF,   1'b1, 0, 0, 0, 1'b1);

        // Hold reset, then release it at a rising edge.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stamp_table[i]) begin
            send_stamp(stamp_table[i].secs, stamp_table[i].typed, stamp_table[i].want);
        end

        // Drop valid and wait for the pipeline to return every directed date.
        s_tvalid <= 1'b0;
        while (date_q.size() != 0) @(posedge aclk);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            // Run a stretch in the middle with both sides streaming at full rate.
            if (i == 400) idle_pct = 0;
            if (i == 600) idle_pct = 11;
            send_stamp(pick_stamp(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (date_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: a correct run finishes well inside this.
    initial begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

endmodule
